FILE: rtl/bbpc_pkg.sv
// Shared types and constants for the binary block pixel counter.
// No dependencies; imported by every module of the block except bbpc_ram.
package bbpc_pkg;

  // Fixed field widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int BLK_CFG_W  = 6;
  localparam int GRID_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int ROW_W      = 11;

  // Row limit of the frame, independent of the width parameter
  localparam int ROWS_LIMIT = 1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;

  // Configuration reset values
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [BLK_CFG_W-1:0]  RST_BLOCK_SIZE   = 6'd16;

  // Per-pixel control from the raster tracker to the accumulator
  typedef struct packed {
    logic              in_grid;
    logic              first;
    logic              last;
    logic              frame_done;
    logic [GRID_W-1:0] grid_col;
    logic [GRID_W-1:0] grid_row;
  } pix_ctrl_t;

endpackage

FILE: rtl/binary_block_pixel_counter_unit.sv
// Binary block pixel counter: one mask pixel per cycle in, one result per whole block out.
// Path: a block's last pixel passes the s1 stage register, then the result register.
// Throughput: one pixel per cycle, limited by the single read-modify-write of the
// column sum RAM; pixels stall only while a finished block waits at a stalled output.
// Reset: synchronous; restores the default 640x480 frame, block size 16, frame start.
// Depends on bbpc_pkg, bbpc_raster, bbpc_accum.
module binary_block_pixel_counter_unit import bbpc_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  logic                  motion_bit,
  output logic                  blk_valid,
  input  logic                  blk_stall,
  output logic [GRID_W-1:0]     grid_col,
  output logic [GRID_W-1:0]     grid_row,
  output logic [COUNT_W-1:0]    set_count,
  output logic                  frame_done
);

  localparam int AW = $clog2(MAX_WIDTH);

  pix_ctrl_t     ctrl;
  logic [AW-1:0] addr;
  logic          pix_accept;

  assign cfg_ready  = 1'b1;
  assign pix_accept = pix_valid && !pix_stall;

  // Track position and classify each pixel
  bbpc_raster #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_raster (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_accept (pix_accept),
    .ctrl       (ctrl),
    .addr       (addr)
  );

  // Accumulate column sums and deliver block results
  bbpc_accum #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .pix_accept (pix_accept),
    .motion_bit (motion_bit),
    .ctrl       (ctrl),
    .addr       (addr),
    .pix_stall  (pix_stall),
    .blk_valid  (blk_valid),
    .blk_stall  (blk_stall),
    .grid_col   (grid_col),
    .grid_row   (grid_row),
    .set_count  (set_count),
    .frame_done (frame_done)
  );

endmodule

FILE: rtl/bbpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbpc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds without rd_en
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/bbpc_raster.sv
// Configuration registers and raster position tracking of the pixel counter.
// Depends on bbpc_pkg.
module bbpc_raster import bbpc_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 32,
  localparam int AW  = $clog2(MAX_WIDTH),
  localparam int GCW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_accept,
  output pix_ctrl_t             ctrl,
  output logic [AW-1:0]         addr
);

  localparam int XW = $clog2(MAX_WIDTH + 2 * MAX_BLOCK + 1);
  localparam int YW = $clog2(ROWS_LIMIT + 2 * MAX_BLOCK + 1);
  localparam int BW = $clog2(MAX_BLOCK + 1);

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [BLK_CFG_W-1:0]  block_size;

  logic [XW-1:0]    w;
  logic [YW-1:0]    h;
  logic [BW-1:0]    b;
  logic [XW-1:0]    b_x;
  logic [YW-1:0]    b_y;

  logic [XW-1:0]    px, px_next;
  logic [BW-1:0]    ox, ox_next;
  logic [GCW-1:0]   col, col_next;
  logic [XW-1:0]    col_start, col_start_next;
  logic [YW-1:0]    py, py_next;
  logic [BW-1:0]    oy, oy_next;
  logic [ROW_W-1:0] row, row_next;
  logic [YW-1:0]    row_start, row_start_next;

  logic restart;
  logic ox_last, oy_last, x_wrap, y_wrap;

  // Any write to a known register restarts the frame
  assign restart = cfg_valid && (cfg_index == CFG_FRAME_WIDTH ||
                                 cfg_index == CFG_FRAME_HEIGHT ||
                                 cfg_index == CFG_BLOCK_SIZE);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      block_size   <= RST_BLOCK_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_BLOCK_SIZE:   block_size   <= cfg_data[BLK_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp configuration to the supported ranges
  always_comb begin
    if (frame_width == '0) begin
      w = XW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = XW'(frame_width);
    end
    if (frame_height == '0) begin
      h = YW'(1);
    end else if (32'(frame_height) > 32'(ROWS_LIMIT)) begin
      h = YW'(ROWS_LIMIT);
    end else begin
      h = YW'(frame_height);
    end
    if (block_size == '0) begin
      b = BW'(1);
    end else if (32'(block_size) > 32'(MAX_BLOCK)) begin
      b = BW'(MAX_BLOCK);
    end else begin
      b = BW'(block_size);
    end
  end

  assign b_x = XW'(b);
  assign b_y = YW'(b);

  // Classify the pixel at the current position
  assign ox_last = (ox == b - BW'(1));
  assign oy_last = (oy == b - BW'(1));
  assign x_wrap  = (px + XW'(1) >= w);
  assign y_wrap  = (py + YW'(1) >= h);

  always_comb begin
    ctrl.in_grid    = (col_start + b_x <= w) && (row_start + b_y <= h);
    ctrl.first      = (ox == '0) && (oy == '0);
    ctrl.last       = ox_last && oy_last;
    ctrl.frame_done = (col_start + b_x + b_x > w) && (row_start + b_y + b_y > h);
    ctrl.grid_col   = GRID_W'(col);
    ctrl.grid_row   = GRID_W'(row);
  end

  assign addr = col[AW-1:0];

  // Advance the raster position by one pixel
  always_comb begin
    px_next        = px + XW'(1);
    ox_next        = ox + BW'(1);
    col_next       = col;
    col_start_next = col_start;
    py_next        = py;
    oy_next        = oy;
    row_next       = row;
    row_start_next = row_start;
    if (ox_last) begin
      ox_next        = '0;
      col_next       = col + GCW'(1);
      col_start_next = col_start + b_x;
    end
    if (x_wrap) begin
      px_next        = '0;
      ox_next        = '0;
      col_next       = '0;
      col_start_next = '0;
      py_next        = py + YW'(1);
      oy_next        = oy + BW'(1);
      if (oy_last) begin
        oy_next        = '0;
        row_next       = row + ROW_W'(1);
        row_start_next = row_start + b_y;
      end
      if (y_wrap) begin
        py_next        = '0;
        oy_next        = '0;
        row_next       = '0;
        row_start_next = '0;
      end
    end
  end

  // Hold position state; restart on reset or register write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      px        <= '0;
      ox        <= '0;
      col       <= '0;
      col_start <= '0;
      py        <= '0;
      oy        <= '0;
      row       <= '0;
      row_start <= '0;
    end else if (pix_accept) begin
      px        <= px_next;
      ox        <= ox_next;
      col       <= col_next;
      col_start <= col_start_next;
      py        <= py_next;
      oy        <= oy_next;
      row       <= row_next;
      row_start <= row_start_next;
    end
  end

endmodule

FILE: rtl/bbpc_accum.sv
// Partial sum stage and result register of the pixel counter.
// Depends on bbpc_pkg and bbpc_ram.
module bbpc_accum import bbpc_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_accept,
  input  logic               motion_bit,
  input  pix_ctrl_t          ctrl,
  input  logic [AW-1:0]      addr,
  output logic               pix_stall,
  output logic               blk_valid,
  input  logic               blk_stall,
  output logic [GRID_W-1:0]  grid_col,
  output logic [GRID_W-1:0]  grid_row,
  output logic [COUNT_W-1:0] set_count,
  output logic               frame_done
);

  logic               s1_valid;
  logic               s1_bit;
  pix_ctrl_t          s1_ctrl;
  logic [AW-1:0]      s1_addr;
  logic               fwd_hit;
  logic [COUNT_W-1:0] fwd_data;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] sum;
  logic               s1_adv;
  logic               rd_en;

  // Column sums, one entry per block column
  bbpc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (sum),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign rd_en = pix_accept && ctrl.in_grid;

  // Advance unless a finished block waits on a stalled result register
  assign s1_adv    = s1_valid && (!s1_ctrl.last || !blk_valid || !blk_stall);
  assign pix_stall = s1_valid && !s1_adv;

  // Take the sum just written when the previous request hit the same column
  assign base = fwd_hit ? fwd_data : rd_data;
  assign sum  = s1_ctrl.first ? COUNT_W'(s1_bit) : base + COUNT_W'(s1_bit);

  // Hold the stage register and forwarding data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (rd_en) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_adv && (s1_addr == addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_bit   <= motion_bit;
      s1_ctrl  <= ctrl;
      s1_addr  <= addr;
      fwd_data <= sum;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (s1_adv && s1_ctrl.last) begin
      blk_valid <= 1'b1;
    end else if (!blk_stall) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl.last) begin
      grid_col   <= s1_ctrl.grid_col;
      grid_row   <= s1_ctrl.grid_row;
      set_count  <= sum;
      frame_done <= s1_ctrl.frame_done;
    end
  end

endmodule

FILE: rtl/bbpc_checker.sv
// Port-level checks for the binary block pixel counter, bound to the top level.
// Depends on bbpc_pkg and binary_block_pixel_counter_unit.
module bbpc_checker import bbpc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  pix_valid,
  input logic                  pix_stall,
  input logic                  blk_valid,
  input logic                  blk_stall,
  input logic [GRID_W-1:0]     grid_col,
  input logic [GRID_W-1:0]     grid_row,
  input logic [COUNT_W-1:0]    set_count,
  input logic                  frame_done
);

  // Hold a stalled result
  a_blk_hold: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_stall |=> blk_valid)
    else $error("result dropped while stalled");

  a_blk_stable: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_stall |=> $stable(grid_col) && $stable(grid_row) &&
                               $stable(set_count) && $stable(frame_done))
    else $error("stalled result changed");

  // Pixels back up only behind a stalled result
  a_pix_stall: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> blk_valid && blk_stall)
    else $error("pixel request stalled with output free");

  // A new result must be preceded by an accepted pixel request
  a_blk_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(blk_valid) |-> $past(pix_valid && !pix_stall, 2))
    else $error("result without a preceding pixel request");

endmodule

bind binary_block_pixel_counter_unit bbpc_checker u_bbpc_checker (.*);

FILE: dv/bbpc_block_count_checker.sv
// Block count checker for the binary block pixel counter: tracks the raster and
// column sums, predicts each block result and compares the accepted results.
// Depends on bbpc_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module bbpc_block_count_checker import bbpc_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_valid,
  input  logic                  pix_stall,
  input  logic                  motion_bit,
  input  logic                  blk_valid,
  input  logic                  blk_stall,
  input  logic [GRID_W-1:0]     grid_col,
  input  logic [GRID_W-1:0]     grid_row,
  input  logic [COUNT_W-1:0]    set_count,
  input  logic                  frame_done,
  output int unsigned           pending_blocks,
  output int unsigned           mismatch_count
);

  typedef struct packed {
    logic [GRID_W-1:0]  col;
    logic [GRID_W-1:0]  row;
    logic [COUNT_W-1:0] count;
    logic               done;
  } block_result_t;

  // Register copies
  logic [CFG_DATA_W-1:0] width_cfg;
  logic [CFG_DATA_W-1:0] height_cfg;
  logic [BLK_CFG_W-1:0]  block_cfg;

  // Raster position and per-column running counts
  logic [ROW_W-1:0]     px, py;
  logic [BLK_CFG_W-1:0] ox, oy;
  logic [ROW_W-1:0]     gcol, grow;
  logic [COUNT_W-1:0]   col_sums [MAX_WIDTH];

  block_result_t expected_blocks [$];
  int unsigned   errs = 0;

  initial begin
    pending_blocks = 0;
    mismatch_count = 0;
  end

  task automatic rewind_frame();
    px = '0;
    py = '0;
    ox = '0;
    oy = '0;
    gcol = '0;
    grow = '0;
  endtask

  // Accumulate one pixel and queue the block result it completes, if any
  task automatic count_pixel(input logic value);
    logic [ROW_W-1:0]     w, h, gw, gh;
    logic [BLK_CFG_W-1:0] b;
    block_result_t        res;
    if (width_cfg == 0) w = ROW_W'(1);
    else if (width_cfg > MAX_WIDTH) w = ROW_W'(MAX_WIDTH);
    else w = width_cfg;
    if (height_cfg == 0) h = ROW_W'(1);
    else if (height_cfg > ROWS_LIMIT) h = ROW_W'(ROWS_LIMIT);
    else h = height_cfg;
    if (block_cfg == 0) b = BLK_CFG_W'(1);
    else if (block_cfg > MAX_BLOCK) b = BLK_CFG_W'(MAX_BLOCK);
    else b = block_cfg;
    gw = w / b;
    gh = h / b;

    if (gcol < gw && grow < gh) begin
      // Top-left pixel of a block starts the column sum afresh
      if (ox == 0 && oy == 0) col_sums[gcol] = {{(COUNT_W-1){1'b0}}, value};
      else col_sums[gcol] = col_sums[gcol] + value;
      if (ox == b - 1'b1 && oy == b - 1'b1) begin
        res.col   = gcol[GRID_W-1:0];
        res.row   = grow[GRID_W-1:0];
        res.count = col_sums[gcol];
        res.done  = (gcol == gw - 1'b1) && (grow == gh - 1'b1);
        expected_blocks.push_back(res);
      end
    end

    // Advance the raster
    px = px + 1'b1;
    ox = ox + 1'b1;
    if (ox >= b) begin
      ox = '0;
      gcol = gcol + 1'b1;
    end
    if (px >= w) begin
      px = '0;
      ox = '0;
      gcol = '0;
      py = py + 1'b1;
      oy = oy + 1'b1;
      if (oy >= b) begin
        oy = '0;
        grow = grow + 1'b1;
      end
      if (py >= h) rewind_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    block_result_t want;
    if (rst) begin
      width_cfg = RST_FRAME_WIDTH;
      height_cfg = RST_FRAME_HEIGHT;
      block_cfg = RST_BLOCK_SIZE;
      rewind_frame();
      expected_blocks.delete();
      foreach (col_sums[i]) col_sums[i] = '0;
    end else begin
      // Compare an accepted result with the oldest prediction
      if (blk_valid && !blk_stall) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected block result: grid_col %0d grid_row %0d set_count %0d",
                 grid_col, grid_row, set_count);
          errs++;
        end else begin
          want = expected_blocks.pop_front();
          if (grid_col !== want.col) begin
            $error("grid_col mismatch: expected %0d, actual %0d", want.col, grid_col);
            errs++;
          end
          if (grid_row !== want.row) begin
            $error("grid_row mismatch: expected %0d, actual %0d", want.row, grid_row);
            errs++;
          end
          if (set_count !== want.count) begin
            $error("set_count mismatch: expected %0d, actual %0d", want.count, set_count);
            errs++;
          end
          if (frame_done !== want.done) begin
            $error("frame_done mismatch: expected %0d, actual %0d", want.done, frame_done);
            errs++;
          end
        end
      end

      // Register writes restart the frame; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            width_cfg = cfg_data;
            rewind_frame();
          end
          CFG_FRAME_HEIGHT: begin
            height_cfg = cfg_data;
            rewind_frame();
          end
          CFG_BLOCK_SIZE: begin
            block_cfg = cfg_data[BLK_CFG_W-1:0];
            rewind_frame();
          end
          default: ;
        endcase
      end

      if (pix_valid && !pix_stall) count_pixel(motion_bit);
    end
    pending_blocks <= expected_blocks.size();
    mismatch_count <= errs;
  end

endmodule

FILE: dv/binary_block_pixel_counter_unit_tb.sv
// Testbench top for binary_block_pixel_counter_unit: drives configuration and
// mask pixels, stalls the result side, and reports the verdict.
// Depends on bbpc_pkg, the block and bbpc_block_count_checker.
`timescale 1ns / 100ps

module binary_block_pixel_counter_unit_tb;
  import bbpc_pkg::*;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_BLOCK      = 32;
  localparam int RANDOM_ITEMS   = 370;
  localparam int DRAIN_CYCLES   = 4;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Directed frame for 5x3 with 2x2 blocks, first pixel in bit 0
  localparam logic [14:0] EDGE_FRAME = 15'b11111_10111_11011;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  pix_valid;
  logic                  pix_stall;
  logic                  motion_bit;
  logic                  blk_valid;
  logic                  blk_stall;
  logic [GRID_W-1:0]     grid_col;
  logic [GRID_W-1:0]     grid_row;
  logic [COUNT_W-1:0]    set_count;
  logic                  frame_done;
  int unsigned           pending_blocks;
  int unsigned           mismatch_count;

  bit          gaps_on = 1'b1;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned idle_cycles = 0;

  binary_block_pixel_counter_unit #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BLOCK(MAX_BLOCK)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .motion_bit(motion_bit),
    .blk_valid(blk_valid),
    .blk_stall(blk_stall),
    .grid_col(grid_col),
    .grid_row(grid_row),
    .set_count(set_count),
    .frame_done(frame_done)
  );

  bbpc_block_count_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BLOCK(MAX_BLOCK)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .motion_bit(motion_bit),
    .blk_valid(blk_valid),
    .blk_stall(blk_stall),
    .grid_col(grid_col),
    .grid_row(grid_row),
    .set_count(set_count),
    .frame_done(frame_done),
    .pending_blocks(pending_blocks),
    .mismatch_count(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned clamp_cfg(input int unsigned value, input int unsigned hi);
    if (value == 0) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  // Offer one pixel request and hold it until accepted
  task automatic push_pixel(input logic value);
    int unsigned gap;
    pix_valid <= 1'b1;
    motion_bit <= value;
    do @(posedge clk); while (pix_stall);
    gap = gaps_on ? idle_gap() : 0;
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_pixels(input int unsigned n, input int unsigned density);
    repeat (n) push_pixel($urandom_range(0, 99) < density);
  endtask

  // Hold a register write request until accepted; valid stays high for the next one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drop pixel requests and wait for the block to go idle
  task automatic settle_block();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending_blocks != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned b);
    settle_block();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_BLOCK_SIZE, b);
    cfg_valid <= 1'b0;
  endtask

  // Result-side stall: random runs, one long hold-off on request
  initial begin
    int unsigned r;
    int unsigned run;
    logic        level;
    blk_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        blk_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          level = 1'b1;
          run = idle_gap() + 1;
        end else if (r < 90) begin
          level = 1'b0;
          run = $urandom_range(1, 8);
        end else begin
          level = 1'b0;
          run = $urandom_range(40, 150);
        end
        blk_stall <= level;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (blk_valid && !blk_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** binary_block_pixel_counter_unit: FAILED **");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int unsigned random_items;
    int unsigned w_raw, h_raw, b_raw;
    int unsigned weff, heff, beff;
    int unsigned frame, n, density;
    int unsigned r;
    random_items = 0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= '0;
    pix_valid <= 1'b0;
    motion_bit <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ignored right column and bottom row, full and partial counts
    configure(5, 3, 2);
    for (int i = 0; i < 15; i++) push_pixel(EDGE_FRAME[i]);
    // Block larger than the frame: no results
    settle_block();
    write_reg(CFG_BLOCK_SIZE, 4);
    cfg_valid <= 1'b0;
    run_pixels(6, 100);
    // Single-pixel blocks; a write to the unused index must not restart the frame
    configure(2, 1, 1);
    push_pixel(1'b1);
    settle_block();
    write_reg(CFG_UNUSED, 11'h7FF);
    cfg_valid <= 1'b0;
    push_pixel(1'b0);
    push_pixel(1'b1);
    push_pixel(1'b1);

    // Fill the block while results are held off
    configure(8, 8, 2);
    hold_armed = 1'b1;
    wait (hold_done);
    gaps_on = 1'b0;
    run_pixels(100, 50);
    gaps_on = 1'b1;

    // Extremes: clamped width and height, tall column, fullest block
    configure(11'h7FF, 0, 1);
    run_pixels(64, 50);
    configure(0, 1024, 1);
    run_pixels(64, 50);
    configure(32, 32, 63);
    run_pixels(1024, 100);

    // Random phases, mostly whole frames of small sizes
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) w_raw = $urandom_range(1, 40);
      else if (r < 90) w_raw = $urandom_range(41, 200);
      else if (r < 95) w_raw = 0;
      else w_raw = $urandom_range(1025, 2047);
      r = $urandom_range(0, 99);
      if (r < 85) h_raw = $urandom_range(1, 20);
      else if (r < 92) h_raw = $urandom_range(21, 64);
      else if (r < 96) h_raw = 0;
      else h_raw = $urandom_range(1025, 2047);
      r = $urandom_range(0, 99);
      if (r < 85) b_raw = $urandom_range(1, 8);
      else if (r < 93) b_raw = $urandom_range(9, 32);
      else if (r < 97) b_raw = 0;
      else b_raw = $urandom_range(33, 63);

      settle_block();
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, $urandom_range(0, 2047));
      write_reg(CFG_FRAME_WIDTH, w_raw);
      write_reg(CFG_FRAME_HEIGHT, h_raw);
      write_reg(CFG_BLOCK_SIZE, b_raw);
      cfg_valid <= 1'b0;

      weff = clamp_cfg(w_raw, MAX_WIDTH);
      heff = clamp_cfg(h_raw, ROWS_LIMIT);
      beff = clamp_cfg(b_raw, MAX_BLOCK);
      frame = weff * heff;
      if (frame <= 400) begin
        n = frame * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(0, frame - 1);
      end else begin
        n = $urandom_range(50, 300);
      end
      // Stop at the item budget
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;

      case ($urandom_range(0, 4))
        0: density = 0;
        1: density = 5;
        2: density = 50;
        3: density = 95;
        default: density = 100;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      run_pixels(n, density);
      random_items += n;
    end
    gaps_on = 1'b1;

    settle_block();
    if (mismatch_count == 0 && pending_blocks == 0) begin
      $display("** binary_block_pixel_counter_unit: PASSED **");
    end else begin
      $display("** binary_block_pixel_counter_unit: FAILED **");
    end
    $finish;
  end

endmodule
